// ===== sv/rps_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and control/status types for the range-to-prefix splitter.
// No dependencies; every other file of the block depends on this package.
package rps_pkg;

  // Default address width and fixed payload field widths.
  localparam int ADDR_WIDTH_DEF = 32;
  localparam int ADDR_W         = 32;
  localparam int BASE_W         = 32;
  localparam int LEN_W          = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture and order the two endpoints
    logic measure;  // compute remaining span and alignment of the cursor
    logic emit;     // register one block and advance the cursor
  } rps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;     // the block under emit reaches the range end
  } rps_sts_t;

endpackage

// ===== sv/rps_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for range input and prefix block output.
// Depends on rps_pkg for the payload field widths.
interface rps_in_if;
  logic                      valid;
  logic                      ready;
  logic [rps_pkg::ADDR_W-1:0] range_first;
  logic [rps_pkg::ADDR_W-1:0] range_second;

  modport source (output valid, output range_first, output range_second, input ready);
  modport sink   (input valid, input range_first, input range_second, output ready);
endinterface

interface rps_out_if;
  logic                      valid;
  logic                      ready;
  logic [rps_pkg::BASE_W-1:0] block_base;
  logic [rps_pkg::LEN_W-1:0]  block_prefix_len;
  logic                      block_last;

  modport source (output valid, output block_base, output block_prefix_len,
                  output block_last, input ready);
  modport sink   (input valid, input block_base, input block_prefix_len,
                  input block_last, output ready);
endinterface

// ===== sv/rps_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the range-to-prefix splitter.
// Depends on rps_pkg for the command and status structs.
module rps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rps_pkg::rps_cmd_t cmd,
  input  rps_pkg::rps_sts_t sts
);
  import rps_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MEAS = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load    = in_valid && (state_r == ST_IDLE);
    cmd.measure = (state_r == ST_MEAS);
    // emit only when the output register is free or drains this cycle
    cmd.emit    = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_MEAS;
      end
      ST_MEAS: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.emit) state_nxt = sts.last ? ST_IDLE : ST_MEAS;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/rps_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the range-to-prefix splitter: cursor, range end, block sizing
// and the output payload register. Depends on rps_pkg.
module rps_dpath #(
  parameter int ADDR_WIDTH = rps_pkg::ADDR_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rps_pkg::rps_cmd_t          cmd,
  output rps_pkg::rps_sts_t          sts,
  input  logic [rps_pkg::ADDR_W-1:0] range_first,
  input  logic [rps_pkg::ADDR_W-1:0] range_second,
  output logic [rps_pkg::BASE_W-1:0] block_base,
  output logic [rps_pkg::LEN_W-1:0]  block_prefix_len,
  output logic                       block_last
);
  import rps_pkg::*;

  localparam int AW = ADDR_WIDTH;
  localparam int SW = ADDR_WIDTH + 1;   // span can be the whole space
  localparam int KW = $clog2(SW);

  logic [AW-1:0]     cur_r, end_r;
  logic [SW-1:0]     rem_r, low_r;
  logic [BASE_W-1:0] base_r;
  logic [LEN_W-1:0]  len_r;
  logic              last_r;

  logic [AW-1:0] a_lo, b_hi;
  logic [SW-1:0] fill, top_bit, size;
  logic [KW-1:0] size_log;
  logic [LEN_W-1:0] len_c;

  always_comb begin
    if (range_first[AW-1:0] > range_second[AW-1:0]) begin
      a_lo = range_second[AW-1:0];
      b_hi = range_first[AW-1:0];
    end else begin
      a_lo = range_first[AW-1:0];
      b_hi = range_second[AW-1:0];
    end
  end

  // Largest power of two not above the remaining span nor the cursor alignment: smear, then isolate.
  always_comb begin
    fill = rem_r;
    for (int s = 1; s < SW; s = s * 2) begin
      fill = fill | (fill >> s);
    end
    top_bit = fill ^ (fill >> 1);
    size    = (low_r < top_bit) ? low_r : top_bit;
    size_log = '0;
    for (int i = 0; i < SW; i++) begin
      if (size[i]) size_log = size_log | KW'(i);
    end
    len_c = LEN_W'(AW) - LEN_W'(size_log);
  end

  assign sts.last = (size == rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      end_r <= '0;
    end else if (cmd.load) begin
      cur_r <= a_lo;
      end_r <= b_hi;
    end else if (cmd.emit) begin
      // wraps to zero past the all-ones address
      cur_r <= cur_r + size[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.measure) begin
      rem_r <= {1'b0, end_r} - {1'b0, cur_r} + SW'(1);
      low_r <= (cur_r == '0) ? (SW'(1) << AW) : {1'b0, cur_r & (~cur_r + AW'(1))};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      base_r <= BASE_W'(cur_r);
      len_r  <= len_c;
      last_r <= sts.last;
    end
  end

  assign block_base       = base_r;
  assign block_prefix_len = len_r;
  assign block_last       = last_r;

endmodule

// ===== sv/range_to_prefix_splitter_core.sv =====
`timescale 1ns / 1ps
// Top level of the range-to-prefix splitter: controller plus datapath.
// Depends on rps_pkg, rps_if, rps_ctrl and rps_dpath.
//
// Usage:
//   in_ch  (sink)   : one transfer carries two inclusive endpoints of an
//                     address range, in either order. Bits above ADDR_WIDTH
//                     are ignored.
//   out_ch (source) : one transfer per aligned prefix block, ascending,
//                     with base, prefix length and a last flag on the block
//                     that reaches the range end.
// Sequencing:
//   A range is loaded while idle, then each block takes a measure step
//   (span and alignment) and an emit step (size and register the block);
//   emit waits while the held block is not taken. N blocks, N is 1 to
//   2*ADDR_WIDTH-2 (62 at 32 bits). The first block follows load, measure
//   and emit. The controller handles one range at a time; in_ch.ready is
//   high only while idle. The output register decouples the sides: a new
//   range is taken while the last block of the previous one still waits.
// Reset:
//   rst_n is synchronous, active low; it drops any run in progress and any
//   held block, and the block comes up idle with in_ch.ready high.
// Stall:
//   With out_ch.ready low, the held block stays stable and the run pauses
//   before registering the next block; nothing is lost.
module range_to_prefix_splitter_core #(
  parameter int ADDR_WIDTH = rps_pkg::ADDR_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rps_in_if.sink    in_ch,
  rps_out_if.source out_ch
);
  import rps_pkg::*;

  // control and status between the two halves
  rps_cmd_t cmd;
  rps_sts_t sts;

  // sequence the run: load, then measure/emit pairs until the last block
  rps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // hold cursor and range end, size each block, register the payload
  rps_dpath #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .range_first      (in_ch.range_first),
    .range_second     (in_ch.range_second),
    .block_base       (out_ch.block_base),
    .block_prefix_len (out_ch.block_prefix_len),
    .block_last       (out_ch.block_last)
  );

endmodule

// ===== sv/rps_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the range-to-prefix splitter, bound to the top.
// Depends on rps_pkg for field widths.
module rps_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rps_pkg::BASE_W-1:0] out_base,
  input logic [rps_pkg::LEN_W-1:0]  out_len,
  input logic                       out_last
);
  import rps_pkg::*;

  // a stalled block holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_base) &&
    $stable(out_len) && $stable(out_last))
    else $error("stalled output block changed");

  // one range at a time: no new range right after a transfer
  a_one_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a run is in progress");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_len <= LEN_W'(ADDR_W))
    else $error("prefix length out of range");

  // host bits of the base are zero
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (BASE_W'(out_base << out_len) == '0))
    else $error("block base not aligned to its prefix");

endmodule

bind range_to_prefix_splitter_core rps_checker u_rps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_base  (out_ch.block_base),
  .out_len   (out_ch.block_prefix_len),
  .out_last  (out_ch.block_last)
);
